// ===== design/topic_wildcard_matcher_macros.svh =====
// Assertion macros shared by the topic wildcard matcher design files.
`ifndef TOPIC_WILDCARD_MATCHER_MACROS_SVH
`define TOPIC_WILDCARD_MATCHER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TWM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/twm_pkg.sv =====
// Package with types and constants for the topic wildcard matcher.
package twm_pkg;

    // Default maximum string length in bytes.
    localparam int MAX_LEN_DEF = 256;

    // Characters with a special meaning in patterns and topics.
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_GT   = 8'h3E;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] PRINT_LO  = 8'h21;
    localparam logic [7:0] PRINT_HI  = 8'h7E;

    // Kind of an input word.
    typedef enum logic {
        REQ_PATTERN = 1'b0,
        REQ_TOPIC   = 1'b1
    } req_t;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_result;
    } status_t;

endpackage

// ===== design/twm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module twm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/twm_ctrl.sv =====
// Controller state machine for the topic wildcard matcher.
module twm_ctrl
    import twm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    // The output register may be reloaded when empty or being emptied now.
    assign slot_free = !m_valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!st.needs_result || slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_EXEC: begin
                if (!st.needs_result) begin
                    cmd.exec = 1'b1;
                end else if (slot_free) begin
                    cmd.exec     = 1'b1;
                    cmd.load_out = 1'b1;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Output word valid flag.
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ===== design/twm_datapath.sv =====
// Datapath of the topic wildcard matcher: pattern store, checkers and matcher.
module twm_datapath
    import twm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    output status_t    st,
    input  logic       in_req,
    input  logic [7:0] in_byte,
    input  logic       in_has,
    input  logic       in_last,
    output logic       out_match,
    output logic       out_pok,
    output logic       out_tok
);

    localparam int AW = $clog2(MAX_LEN > 1 ? MAX_LEN : 2);
    localparam int LW = $clog2(MAX_LEN + 2);
    localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_LEN);
    localparam logic [LW-1:0] LEN_OVER = LW'(MAX_LEN + 1);
    localparam logic [LW-1:0] LEN_ONE  = LW'(1);

    // Captured input word.
    logic       req_reg;
    logic [7:0] byte_reg;
    logic       has_reg;
    logic       last_reg;

    // Pattern state.
    logic [LW-1:0] plen_reg, plen_next;
    logic          pval_reg, pval_next;
    logic [1:0]    pcnt_reg, pcnt_next;
    logic          pstar_reg, pstar_next;
    logic          pgt_reg, pgt_next;
    logic          pload_reg, pload_next;

    // Topic and match state.
    logic [LW-1:0] ptr_reg, ptr_next;
    logic [LW-1:0] tlen_reg, tlen_next;
    logic          tne_reg, tne_next;
    logic          tval_reg, tval_next;
    logic          mis_reg, mis_next;
    logic          tail_reg, tail_next;
    logic          wild_reg, wild_next;

    // Result word.
    logic out_match_reg, out_pok_reg, out_tok_reg;
    logic res_match, res_pok, res_tok;

    // Pattern store ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_rdata;

    twm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_reg),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Capture the accepted word.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= in_req;
            byte_reg <= in_byte;
            has_reg  <= in_has;
            last_reg <= in_last;
        end
    end

    assign st.needs_result = (req_reg == REQ_TOPIC) && last_reg;

    // Processing of one word: validation, pattern load and segment matching.
    always_comb begin
        logic printable;
        logic is_dot;
        logic is_wild;
        logic ptr_ok;

        plen_next  = plen_reg;
        pval_next  = pval_reg;
        pcnt_next  = pcnt_reg;
        pstar_next = pstar_reg;
        pgt_next   = pgt_reg;
        pload_next = pload_reg;
        ptr_next   = ptr_reg;
        tlen_next  = tlen_reg;
        tne_next   = tne_reg;
        tval_next  = tval_reg;
        mis_next   = mis_reg;
        tail_next  = tail_reg;
        wild_next  = wild_reg;
        ram_we     = 1'b0;
        ram_waddr  = plen_reg[AW-1:0];
        res_match  = 1'b0;
        res_pok    = 1'b0;
        res_tok    = 1'b0;

        printable = (byte_reg >= PRINT_LO) && (byte_reg <= PRINT_HI);
        is_dot    = (byte_reg == CHAR_DOT);
        is_wild   = (byte_reg == CHAR_STAR) || (byte_reg == CHAR_GT);
        ptr_ok    = (ptr_reg < plen_reg) && (ptr_reg < LEN_MAX);

        if (cmd.exec && (has_reg || last_reg)) begin
            if (req_reg == REQ_PATTERN) begin
                // A pattern word discards any partial topic.
                ptr_next  = '0;
                tlen_next = '0;
                tne_next  = 1'b0;
                tval_next = 1'b1;
                mis_next  = 1'b0;
                tail_next = 1'b0;
                wild_next = 1'b0;
                if (!pload_reg) begin
                    plen_next  = '0;
                    pval_next  = 1'b1;
                    pcnt_next  = 2'd0;
                    pstar_next = 1'b0;
                    pgt_next   = 1'b0;
                    pload_next = 1'b1;
                end
                if (has_reg) begin
                    ram_waddr = plen_next[AW-1:0];
                    if (plen_next < LEN_MAX) begin
                        ram_we    = 1'b1;
                        plen_next = plen_next + LEN_ONE;
                    end else begin
                        plen_next = LEN_OVER;
                        pval_next = 1'b0;
                    end
                    if (!printable) begin
                        pval_next = 1'b0;
                    end
                    if (is_dot) begin
                        if (pcnt_next == 2'd0 || (pcnt_next == 2'd1 && pgt_next)) begin
                            pval_next = 1'b0;
                        end
                        pcnt_next  = 2'd0;
                        pstar_next = 1'b0;
                        pgt_next   = 1'b0;
                    end else begin
                        if (pcnt_next != 2'd0 && is_wild) begin
                            pval_next = 1'b0;
                        end
                        if (pcnt_next == 2'd1 && (pstar_next || pgt_next)) begin
                            pval_next = 1'b0;
                        end
                        if (pcnt_next == 2'd0) begin
                            if (byte_reg == CHAR_STAR) begin
                                pstar_next = 1'b1;
                            end
                            if (byte_reg == CHAR_GT) begin
                                pgt_next = 1'b1;
                            end
                        end
                        if (pcnt_next != 2'd2) begin
                            pcnt_next = pcnt_next + 2'd1;
                        end
                    end
                end
                if (last_reg) begin
                    if (pcnt_next == 2'd0) begin
                        pval_next = 1'b0;
                    end
                    pload_next = 1'b0;
                end
            end else begin
                // A topic word cuts short an unfinished pattern load.
                if (pload_reg) begin
                    pval_next  = 1'b0;
                    pload_next = 1'b0;
                end
                if (has_reg) begin
                    if (tlen_reg < LEN_MAX) begin
                        tlen_next = tlen_reg + LEN_ONE;
                    end else begin
                        tlen_next = LEN_OVER;
                        tval_next = 1'b0;
                    end
                    if (!printable || is_wild) begin
                        tval_next = 1'b0;
                    end
                    if (is_dot) begin
                        if (!tne_reg) begin
                            tval_next = 1'b0;
                        end
                        tne_next = 1'b0;
                    end else begin
                        tne_next = 1'b1;
                    end
                    // Segment matching against the stored pattern byte.
                    if (!mis_reg && !tail_reg) begin
                        if (wild_reg) begin
                            if (is_dot) begin
                                wild_next = 1'b0;
                                if (ptr_ok && ram_rdata == CHAR_DOT) begin
                                    ptr_next = ptr_reg + LEN_ONE;
                                end else begin
                                    mis_next = 1'b1;
                                end
                            end
                        end else if (!ptr_ok) begin
                            mis_next = 1'b1;
                        end else if (ram_rdata == CHAR_GT) begin
                            tail_next = 1'b1;
                        end else if (ram_rdata == CHAR_STAR) begin
                            wild_next = 1'b1;
                            ptr_next  = ptr_reg + LEN_ONE;
                        end else if (ram_rdata == byte_reg) begin
                            ptr_next = ptr_reg + LEN_ONE;
                        end else begin
                            mis_next = 1'b1;
                        end
                    end
                end
                if (last_reg) begin
                    if (!tne_next) begin
                        tval_next = 1'b0;
                    end
                    res_pok   = pval_next;
                    res_tok   = tval_next;
                    res_match = pval_next && tval_next && !mis_next &&
                                (tail_next || ptr_next == plen_next);
                    ptr_next  = '0;
                    tlen_next = '0;
                    tne_next  = 1'b0;
                    tval_next = 1'b1;
                    mis_next  = 1'b0;
                    tail_next = 1'b0;
                    wild_next = 1'b0;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg  <= '0;
            pval_reg  <= 1'b0;
            pcnt_reg  <= 2'd0;
            pstar_reg <= 1'b0;
            pgt_reg   <= 1'b0;
            pload_reg <= 1'b0;
            ptr_reg   <= '0;
            tlen_reg  <= '0;
            tne_reg   <= 1'b0;
            tval_reg  <= 1'b1;
            mis_reg   <= 1'b0;
            tail_reg  <= 1'b0;
            wild_reg  <= 1'b0;
        end else begin
            plen_reg  <= plen_next;
            pval_reg  <= pval_next;
            pcnt_reg  <= pcnt_next;
            pstar_reg <= pstar_next;
            pgt_reg   <= pgt_next;
            pload_reg <= pload_next;
            ptr_reg   <= ptr_next;
            tlen_reg  <= tlen_next;
            tne_reg   <= tne_next;
            tval_reg  <= tval_next;
            mis_reg   <= mis_next;
            tail_reg  <= tail_next;
            wild_reg  <= wild_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_match_reg <= res_match;
            out_pok_reg   <= res_pok;
            out_tok_reg   <= res_tok;
        end
    end

    assign out_match = out_match_reg;
    assign out_pok   = out_pok_reg;
    assign out_tok   = out_tok_reg;

endmodule

// ===== design/topic_wildcard_matcher.sv =====
// Top level of the topic wildcard matcher: controller, datapath and checks.
//
// A pattern string is streamed in first (tuser low), one byte per word, and
// kept in an internal store; topic strings (tuser high) are then streamed in
// and matched segment by segment against it. tlast marks the final word of
// a string; a word with has_byte low and tlast high ends an empty string.
// After the last word of a topic one result word leaves on the master side
// with the match flag and the validity flags of pattern and topic. Pattern
// words produce no result. The pattern stays stored for any later topics.
// Each input word is taken in the idle state and processed in the execute
// state before the next word is accepted; while the word is taken, the
// registered read port of the pattern store fetches the pattern byte, which
// is compared in the following cycle. A topic's result is registered once
// its last word is processed. A waiting result does not stop further words;
// only the final word of a new topic waits until the output register is free.
// A stalled receiver thus holds at most one result. Reset is synchronous
// and active low; it empties the output, clears the pattern (pattern_ok
// low until one is loaded) and ends any topic in progress.
`include "topic_wildcard_matcher_macros.svh"

module topic_wildcard_matcher
    import twm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] data_byte, [8] has_byte, [15:9] zero
    input  logic [15:0] s_tdata,
    // s_tuser: [0] req_type
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [0] matches_res, [1] pattern_ok, [2] topic_ok, [7:3] zero
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    cmd_t    cmd;
    status_t st;
    logic    out_match, out_pok, out_tok;
    logic    topic_end_free;

    // Sequencing of words and of the output register.
    twm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Store, validation and matching.
    twm_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .in_req    (s_tuser[0]),
        .in_byte   (s_tdata[7:0]),
        .in_has    (s_tdata[8]),
        .in_last   (s_tlast),
        .out_match (out_match),
        .out_pok   (out_pok),
        .out_tok   (out_tok)
    );

    assign m_tdata = {5'd0, out_tok, out_pok, out_match};

    // Final word of a topic taken while the output register is empty.
    assign topic_end_free = s_tvalid && s_tready && (s_tuser[0] == REQ_TOPIC) &&
                            s_tlast && !m_tvalid;

    // A new result never overwrites one that is still waiting.
    `TWM_ASSERT_SAME(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready, "result overwritten")

    // The last word of a topic with a free output register is answered next cycle.
    `TWM_ASSERT_NEXT(a_topic_result, topic_end_free, cmd.load_out, "topic result not produced")

endmodule

// ===== tb/tb_topic_wildcard_matcher.sv =====
// Self-checking testbench for the topic wildcard matcher: random streams of patterns and topics.
`timescale 1ns / 100ps

module tb_topic_wildcard_matcher;
    import twm_pkg::*;

    localparam int STR_MAX        = MAX_LEN_DEF;
    localparam int TOTAL_WORDS    = 1650;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;

    // A pattern or topic string, one byte per entry.
    typedef logic [7:0] text_t[$];

    // One word waiting to be offered on the slave side.
    typedef struct {
        req_t       kind;
        logic [7:0] ch;
        logic       has;
        logic       lst;
        logic       drain;
    } word_t;

    // Verdict for one topic, bit order as on m_tdata.
    typedef struct packed {
        logic topic_ok;
        logic pattern_ok;
        logic hit;
    } verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    topic_wildcard_matcher #(
        .MAX_LEN(STR_MAX)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always #5 aclk = ~aclk;

    // Words still to be offered, and verdicts still to arrive.
    word_t    word_backlog[$];
    verdict_t expected_verdicts[$];

    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    int   fault_cnt   = 0;
    int   verdict_cnt = 0;
    int   quiet_cycles = 0;
    int   stim_count  = 0;
    logic drain_next  = 1'b0;

    // Shadow of the matcher state.
    logic [7:0]  pat_mem [0:STR_MAX-1];
    int unsigned pat_len = 0;
    logic        pat_ok  = 1'b0;
    int unsigned seg_cnt = 0;
    logic        seg_star = 1'b0;
    logic        seg_gt   = 1'b0;
    logic        loading  = 1'b0;
    int unsigned cmp_ptr = 0;
    int unsigned top_len = 0;
    logic        top_nonempty = 1'b0;
    logic        top_ok   = 1'b1;
    logic        cmp_miss = 1'b0;
    logic        cmp_tail = 1'b0;
    logic        cmp_wild = 1'b0;

    // Forget any topic in progress.
    task automatic topic_restart();
        cmp_ptr      = 0;
        top_len      = 0;
        top_nonempty = 1'b0;
        top_ok       = 1'b1;
        cmp_miss     = 1'b0;
        cmp_tail     = 1'b0;
        cmp_wild     = 1'b0;
    endtask

    // Advance the shadow state by one accepted word, queueing a verdict when a topic ends.
    task automatic subject_match_step(req_t kind, logic [7:0] ch, logic has, logic lst);
        verdict_t    v;
        logic        printable;
        logic        wild;
        int unsigned cnt;
        printable = (ch >= PRINT_LO) && (ch <= PRINT_HI);
        wild      = (ch == CHAR_STAR) || (ch == CHAR_GT);
        if (!has && !lst) return;

        if (kind == REQ_PATTERN) begin
            topic_restart();
            if (!loading) begin
                pat_len  = 0;
                pat_ok   = 1'b1;
                seg_cnt  = 0;
                seg_star = 1'b0;
                seg_gt   = 1'b0;
                loading  = 1'b1;
            end
            if (has) begin
                cnt = seg_cnt;
                if (pat_len < STR_MAX) begin
                    pat_mem[pat_len] = ch;
                    pat_len++;
                end else begin
                    pat_len = STR_MAX + 1;
                    pat_ok  = 1'b0;
                end
                if (!printable) pat_ok = 1'b0;
                if (ch == CHAR_DOT) begin
                    // An empty segment, or '>' that is not the final segment.
                    if (cnt == 0 || (cnt == 1 && seg_gt)) pat_ok = 1'b0;
                    seg_cnt  = 0;
                    seg_star = 1'b0;
                    seg_gt   = 1'b0;
                end else begin
                    // Wildcards must stand alone in their segment.
                    if (cnt >= 1 && wild) pat_ok = 1'b0;
                    if (cnt == 1 && (seg_star || seg_gt)) pat_ok = 1'b0;
                    if (cnt == 0 && ch == CHAR_STAR) seg_star = 1'b1;
                    if (cnt == 0 && ch == CHAR_GT) seg_gt = 1'b1;
                    if (cnt < 2) seg_cnt = cnt + 1;
                end
            end
            if (lst) begin
                if (seg_cnt == 0) pat_ok = 1'b0;
                loading = 1'b0;
            end
            return;
        end

        // A topic word cuts short any unfinished pattern.
        if (loading) begin
            pat_ok  = 1'b0;
            loading = 1'b0;
        end
        if (has) begin
            if (top_len < STR_MAX) begin
                top_len++;
            end else begin
                top_len = STR_MAX + 1;
                top_ok  = 1'b0;
            end
            if (!printable || wild) top_ok = 1'b0;
            if (ch == CHAR_DOT) begin
                if (!top_nonempty) top_ok = 1'b0;
                top_nonempty = 1'b0;
            end else begin
                top_nonempty = 1'b1;
            end

            // Segment comparison against the stored pattern.
            if (!cmp_miss && !cmp_tail) begin
                if (cmp_wild) begin
                    if (ch == CHAR_DOT) begin
                        cmp_wild = 1'b0;
                        if (cmp_ptr < pat_len && cmp_ptr < STR_MAX &&
                            pat_mem[cmp_ptr] == CHAR_DOT)
                            cmp_ptr++;
                        else
                            cmp_miss = 1'b1;
                    end
                end else if (cmp_ptr >= pat_len || cmp_ptr >= STR_MAX) begin
                    cmp_miss = 1'b1;
                end else if (pat_mem[cmp_ptr] == CHAR_GT) begin
                    cmp_tail = 1'b1;
                end else if (pat_mem[cmp_ptr] == CHAR_STAR) begin
                    cmp_wild = 1'b1;
                    cmp_ptr++;
                end else if (pat_mem[cmp_ptr] == ch) begin
                    cmp_ptr++;
                end else begin
                    cmp_miss = 1'b1;
                end
            end
        end
        if (!lst) return;

        if (!top_nonempty) top_ok = 1'b0;
        v.topic_ok   = top_ok;
        v.pattern_ok = pat_ok;
        v.hit        = pat_ok && top_ok && !cmp_miss && (cmp_tail || cmp_ptr == pat_len);
        expected_verdicts.push_back(v);
        topic_restart();
    endtask

    task automatic note_fault(string msg);
        fault_cnt++;
        if (fault_cnt <= 10) $display("%t: %s", $realtime, msg);
    endtask

    // Sample both handshakes, predict, check and watch for a hang.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn) begin
            s_taken <= s_tvalid && s_tready;
            m_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                verdict_cnt++;
                if (expected_verdicts.size() == 0) begin
                    note_fault($sformatf("result %0d arrived with none outstanding",
                                         verdict_cnt));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[0] !== want.hit || m_tdata[1] !== want.pattern_ok ||
                        m_tdata[2] !== want.topic_ok)
                        note_fault($sformatf(
                            {"result %0d: expected match=%0b pattern_ok=%0b topic_ok=%0b,",
                             " got %0b %0b %0b"},
                            verdict_cnt, want.hit, want.pattern_ok, want.topic_ok,
                            m_tdata[0], m_tdata[1], m_tdata[2]));
                end
            end
            if (s_tvalid && s_tready)
                subject_match_step(req_t'(s_tuser[0]), s_tdata[7:0], s_tdata[8], s_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Sender: offers the backlog word by word with random gaps.
    int   src_gap  = 0;
    logic src_fast = 1'b0;
    always @(negedge aclk) begin
        logic offer;
        offer = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_taken) begin
                void'(word_backlog.pop_front());
                offer   = 1'b0;
                src_gap = src_fast ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 63) == 0) src_fast = !src_fast;
            end
            if (!offer) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (word_backlog.size() > 0 &&
                             !(word_backlog[0].drain && expected_verdicts.size() > 0)) begin
                    s_tdata <= {7'b0, word_backlog[0].has, word_backlog[0].ch};
                    s_tuser <= word_backlog[0].kind;
                    s_tlast <= word_backlog[0].lst;
                    offer = 1'b1;
                end
            end
        end
        s_tvalid <= offer;
    end

    // Receiver: random gaps per word, and two long hold-offs.
    int   sink_gap  = 0;
    logic sink_fast = 1'b0;
    always @(negedge aclk) begin
        logic rdy;
        rdy = m_tready;
        if (aresetn) begin
            if (m_taken) begin
                rdy      = 1'b0;
                sink_gap = sink_fast ? 0 : $urandom_range(0, 3);
                if (verdict_cnt == 30 || verdict_cnt == 45) sink_gap = LONG_HOLD;
                if ($urandom_range(0, 63) == 0) sink_fast = !sink_fast;
            end
            if (!rdy) begin
                if (sink_gap > 0) sink_gap--;
                else rdy = 1'b1;
            end
        end
        m_tready <= rdy;
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic text_t txt(string s);
        text_t t;
        for (int i = 0; i < s.len(); i++) t.push_back(s.getc(i));
        return t;
    endfunction

    function automatic text_t repeat_char(logic [7:0] ch, int n);
        text_t t;
        for (int i = 0; i < n; i++) t.push_back(ch);
        return t;
    endfunction

    // A short literal segment over a small alphabet, so that literals often agree.
    function automatic text_t rand_seg();
        text_t t;
        int    n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
        for (int i = 0; i < n; i++) t.push_back(8'($urandom_range(8'h61, 8'h63)));
        return t;
    endfunction

    task automatic push_word(req_t kind, logic [7:0] ch, logic has, logic lst);
        word_t w;
        w.kind  = kind;
        w.ch    = ch;
        w.has   = has;
        w.lst   = lst;
        w.drain = drain_next;
        drain_next = 1'b0;
        word_backlog.push_back(w);
        if (has || lst) stim_count++;
    endtask

    // Queue a string; when it is closed, the final word carries tlast.
    task automatic push_text(req_t kind, text_t t, logic close);
        int   n;
        logic byteless_tail;
        n = t.size();
        byteless_tail = close && ($urandom_range(0, 9) == 0);
        if (n == 0) begin
            if (close) push_word(kind, any_byte(), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 24) == 0) push_word(kind, any_byte(), 1'b0, 1'b0);
            push_word(kind, t[i], 1'b1, close && !byteless_tail && i == n - 1);
        end
        if (byteless_tail) push_word(kind, any_byte(), 1'b0, 1'b1);
    endtask

    // One corruption of a string: changed letters, stray dots, wildcards, odd bytes, lost characters, an extra segment.
    function automatic text_t garble(text_t t);
        text_t g;
        text_t extra;
        int    pos;
        g   = t;
        pos = $urandom_range(0, g.size());
        case ($urandom_range(0, 6))
            0: if (g.size() > 0)
                   g[$urandom_range(0, g.size() - 1)] = 8'($urandom_range(8'h61, 8'h64));
            1: g.insert(pos, CHAR_DOT);
            2: g.insert(pos, ($urandom_range(0, 1) == 0) ? CHAR_STAR : CHAR_GT);
            3: g.insert(pos, any_byte());
            4: if (g.size() > 0) g.delete($urandom_range(0, g.size() - 1));
            5: begin
                extra = rand_seg();
                g.push_back(CHAR_DOT);
                foreach (extra[i]) g.push_back(extra[i]);
            end
            default: begin
                if ($urandom_range(0, 1) == 0) g.push_front(CHAR_DOT);
                else g.push_back(CHAR_DOT);
            end
        endcase
        return g;
    endfunction

    // A topic built to fit a pattern: '*' takes one segment, '>' one to three.
    function automatic text_t topic_for(text_t pat);
        text_t tp;
        text_t seg;
        text_t lit;
        int    reps;
        for (int i = 0; i <= pat.size(); i++) begin
            if (i < pat.size() && pat[i] != CHAR_DOT) begin
                seg.push_back(pat[i]);
            end else begin
                if (seg.size() == 1 && seg[0] == CHAR_STAR) begin
                    lit = rand_seg();
                    foreach (lit[k]) tp.push_back(lit[k]);
                end else if (seg.size() == 1 && seg[0] == CHAR_GT) begin
                    reps = $urandom_range(1, 3);
                    for (int r = 0; r < reps; r++) begin
                        if (r > 0) tp.push_back(CHAR_DOT);
                        lit = rand_seg();
                        foreach (lit[k]) tp.push_back(lit[k]);
                    end
                end else begin
                    foreach (seg[k]) tp.push_back(seg[k]);
                end
                if (i < pat.size()) tp.push_back(CHAR_DOT);
                seg.delete();
            end
        end
        return tp;
    endfunction

    // Stimulus, then wait for the last verdict.
    initial begin
        text_t pat;
        text_t tp;
        text_t seg;
        int    nseg;
        int    ntop;
        int    roll;
        int    group;

        // Topic before any pattern has been loaded.
        push_text(REQ_TOPIC, txt("a.b"), 1'b1);
        // Pattern with both wildcards, against fitting, short, long and bad topics.
        push_text(REQ_PATTERN, txt("a.*.>"), 1'b1);
        push_text(REQ_TOPIC, txt("a.b.c"), 1'b1);
        push_text(REQ_TOPIC, txt("a.xy.c.d"), 1'b1);
        push_text(REQ_TOPIC, txt("a.b"), 1'b1);
        push_text(REQ_TOPIC, txt("a.b."), 1'b1);
        push_text(REQ_TOPIC, txt("a.*.c"), 1'b1);
        tp = txt("a.");
        tp.push_back(8'hFF);
        tp.push_back(CHAR_DOT);
        tp.push_back(8'h01);
        push_text(REQ_TOPIC, tp, 1'b1);
        // Empty topic, and a byteless word without tlast that must be ignored.
        push_word(REQ_TOPIC, 8'hFF, 1'b0, 1'b0);
        push_word(REQ_TOPIC, 8'h01, 1'b0, 1'b1);
        // Malformed patterns.
        push_text(REQ_PATTERN, txt("a.>.b"), 1'b1);
        push_text(REQ_TOPIC, txt("a.c.b"), 1'b1);
        push_text(REQ_PATTERN, txt("a*"), 1'b1);
        push_text(REQ_TOPIC, txt("a*"), 1'b1);
        push_text(REQ_PATTERN, txt("a..b"), 1'b1);
        push_text(REQ_TOPIC, txt("a..b"), 1'b1);
        // Empty pattern.
        push_word(REQ_PATTERN, 8'h7E, 1'b0, 1'b1);
        push_text(REQ_TOPIC, txt("x"), 1'b1);
        // Lone wildcard patterns, after the sender has waited for all verdicts.
        drain_next = 1'b1;
        push_text(REQ_PATTERN, txt("*"), 1'b1);
        push_text(REQ_TOPIC, txt("abc"), 1'b1);
        push_text(REQ_TOPIC, txt("ab.c"), 1'b1);
        push_text(REQ_PATTERN, txt(">"), 1'b1);
        push_text(REQ_TOPIC, txt("x.y.z"), 1'b1);
        // A topic cut off by a new pattern, and a pattern cut off by a topic.
        push_text(REQ_TOPIC, txt("a.b"), 1'b0);
        push_text(REQ_PATTERN, txt("a.b"), 1'b1);
        push_text(REQ_TOPIC, txt("a.b"), 1'b1);
        push_text(REQ_PATTERN, txt("x"), 1'b0);
        push_text(REQ_TOPIC, txt("x"), 1'b1);
        // Longest strings and one byte beyond.
        push_text(REQ_PATTERN, repeat_char(8'h71, STR_MAX), 1'b1);
        push_text(REQ_TOPIC, repeat_char(8'h71, STR_MAX), 1'b1);
        push_text(REQ_TOPIC, repeat_char(8'h71, STR_MAX + 1), 1'b1);
        push_text(REQ_PATTERN, repeat_char(8'h71, STR_MAX + 1), 1'b1);
        push_text(REQ_TOPIC, repeat_char(8'h71, STR_MAX), 1'b1);

        // Random part up to the total word count: mostly well-formed pattern groups.
        group = 0;
        while (stim_count < TOTAL_WORDS) begin
            roll = $urandom_range(0, 99);
            if (roll < 82) begin
                pat.delete();
                nseg = $urandom_range(1, 4);
                for (int s = 0; s < nseg; s++) begin
                    if (s > 0) pat.push_back(CHAR_DOT);
                    if (s == nseg - 1 && $urandom_range(0, 3) == 0) begin
                        pat.push_back(CHAR_GT);
                    end else if ($urandom_range(0, 2) == 0) begin
                        pat.push_back(CHAR_STAR);
                    end else begin
                        seg = rand_seg();
                        foreach (seg[k]) pat.push_back(seg[k]);
                    end
                end
                if (group % 25 == 0) drain_next = 1'b1;
                group++;
                if ($urandom_range(0, 19) == 0) begin
                    // Topic arriving before the pattern is closed.
                    push_text(REQ_PATTERN, pat, 1'b0);
                end else begin
                    push_text(REQ_PATTERN, ($urandom_range(0, 6) == 0) ? garble(pat) : pat,
                              1'b1);
                end
                ntop = $urandom_range(2, 8);
                for (int n = 0; n < ntop; n++) begin
                    tp = topic_for(pat);
                    if ($urandom_range(0, 3) == 0) tp = garble(tp);
                    // Now and then the topic is left open for the next pattern to cut off.
                    push_text(REQ_TOPIC, tp, !(n == ntop - 1 && $urandom_range(0, 19) == 0));
                end
            end else begin
                for (int n = $urandom_range(1, 12); n > 0; n--)
                    push_word(req_t'($urandom_range(0, 1)), any_byte(),
                              $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
            end
        end

        while (word_backlog.size() != 0 || expected_verdicts.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fault_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Reset held from the start, released on a falling edge.
    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
    end

endmodule
